>>> rtl/slir_pkg.sv
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [IDX_W-1:0]         index_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_LIST
  } fsm_state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    data_t    key;
    count_t   count;
    data_t    head;
  } cell_cmd_t;

  // compare flags a cell hands to its right neighbor and to the control
  typedef struct packed {
    logic gt;
    logic eq;
  } cell_flags_t;

endpackage

>>> rtl/slir_if.sv
interface slir_req_if import slir_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  data_t           value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface slir_rsp_if import slir_pkg::*; ();
  logic              valid;
  logic              ready;
  data_t             element;
  logic              last;
  logic [STAT_W-1:0] status;

  modport source (output valid, output element, output last, output status, input ready);
  modport sink   (input valid, input element, input last, input status, output ready);
endinterface

>>> rtl/slir_cell.sv
module slir_cell import slir_pkg::*; (
  input  logic        clk_i,
  input  index_t      index_i,
  input  cell_cmd_t   cmd_i,
  input  logic        found_i,
  input  data_t       left_val_i,
  input  cell_flags_t left_flags_i,
  input  data_t       right_val_i,
  output data_t       val_o,
  output cell_flags_t flags_o
);

  data_t  val_q, val_d;
  count_t pos;
  logic   occupied;
  logic   at_free;
  logic   last_occ;
  logic   ge;

  assign pos      = {1'b0, index_i};
  assign occupied = pos < cmd_i.count;
  assign at_free  = pos == cmd_i.count;
  assign last_occ = count_t'(pos + count_t'(1)) == cmd_i.count;
  assign ge       = occupied && (val_q >= cmd_i.key);

  assign flags_o.gt = occupied && (val_q > cmd_i.key);
  assign flags_o.eq = occupied && (val_q == cmd_i.key);
  assign val_o      = val_q;

  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        // everything above the key moves one cell right, key drops into the gap
        if (left_flags_i.gt) begin
          val_d = left_val_i;
        end else if (flags_o.gt || at_free) begin
          val_d = cmd_i.key;
        end
      end
      CELL_REMOVE: begin
        if (found_i && ge) begin
          val_d = right_val_i;
        end
      end
      CELL_ROTATE: begin
        // head wraps around into the last occupied cell
        if (last_occ) begin
          val_d = cmd_i.head;
        end else if (occupied) begin
          val_d = right_val_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> rtl/sorted_list_insert_remove.sv
// Sorted store of up to CAPACITY signed 32-bit values held in a chain of
// compare-and-shift cells. An insert or remove updates every cell in the
// cycle the request is accepted and returns one status result; the next
// request can be taken in the cycle that result leaves the output register.
// A list request streams the stored values in ascending order, one per cycle
// while the sink keeps ready high, by rotating the chain toward cell 0, so it
// occupies the block until the last stored value is loaded (an empty store
// gives a single result with an empty status and the block stays idle); after a
// full rotation the chain is back in order. Throughput is set by the output
// register: one result per cycle while the sink keeps ready high.
module sorted_list_insert_remove import slir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  slir_req_if.sink          req_i,
  slir_rsp_if.source        rsp_o
);

  fsm_state_e  state_q, state_d;
  count_t      count_q, count_d;
  index_t      idx_q, idx_d;

  logic        rsp_valid_q;
  data_t       rsp_element_q;
  logic        rsp_last_q;
  status_e     rsp_status_q;

  logic        load;
  data_t       load_element;
  logic        load_last;
  status_e     load_status;

  cell_cmd_t   cmd;
  data_t       vals  [CAPACITY];
  cell_flags_t flags [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic        found;
  logic        req_fire;
  logic        out_free;
  logic        last_item;
  op_e         req_op;

  assign req_op    = op_e'(req_i.operation);
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == FSM_IDLE) && out_free;
  assign req_fire  = req_i.valid && req_i.ready;
  assign last_item = count_t'({1'b0, idx_q} + count_t'(1)) == count_q;
  assign found     = |eq_vec;

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t       left_val;
    cell_flags_t left_flags;
    data_t       right_val;

    if (g == 0) begin : g_first
      assign left_val   = '0;
      assign left_flags = '0;
    end else begin : g_mid
      assign left_val   = vals[g-1];
      assign left_flags = flags[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = vals[g+1];
    end

    slir_cell u_cell (
      .clk_i        (clk_i),
      .index_i      (index_t'(g)),
      .cmd_i        (cmd),
      .found_i      (found),
      .left_val_i   (left_val),
      .left_flags_i (left_flags),
      .right_val_i  (right_val),
      .val_o        (vals[g]),
      .flags_o      (flags[g])
    );

    assign eq_vec[g] = flags[g].eq;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_fire && (req_op == OP_LIST) && (count_q != '0)) begin
          state_d = FSM_LIST;
        end
      end
      FSM_LIST: begin
        if (out_free && last_item) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.key      = req_i.value;
    cmd.count    = count_q;
    cmd.head     = vals[0];
    count_d      = count_q;
    idx_d        = idx_q;
    load         = 1'b0;
    load_element = '0;
    load_last    = 1'b1;
    load_status  = STATUS_OK;
    case (state_q)
      FSM_IDLE: begin
        if (req_fire) begin
          case (req_op)
            OP_INSERT: begin
              load = 1'b1;
              if (count_q == count_t'(CAPACITY)) begin
                load_status = STATUS_FULL;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + count_t'(1);
              end
            end
            OP_REMOVE: begin
              load   = 1'b1;
              cmd.op = CELL_REMOVE;
              if (found) begin
                count_d = count_q - count_t'(1);
              end else begin
                load_status = STATUS_NOT_FOUND;
              end
            end
            OP_LIST: begin
              idx_d = '0;
              if (count_q == '0) begin
                load        = 1'b1;
                load_status = STATUS_EMPTY;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      FSM_LIST: begin
        if (out_free) begin
          cmd.op       = CELL_ROTATE;
          load         = 1'b1;
          load_element = vals[0];
          load_last    = last_item;
          idx_d        = idx_q + index_t'(1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_element_q <= load_element;
      rsp_last_q    <= load_last;
      rsp_status_q  <= load_status;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.element = rsp_element_q;
  assign rsp_o.last    = rsp_last_q;
  assign rsp_o.status  = rsp_status_q;

  // occupied cells are in ascending order whenever no list is rotating them
  logic [CAPACITY-2:0] order_ok;
  for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order
    assign order_ok[g] = (count_t'(g + 1) >= count_q) || (vals[g] <= vals[g+1]);
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_list_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_LIST) |-> ({1'b0, idx_q} < count_q))
    else $error("list index past the stored entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_op == OP_INSERT) && (count_q != count_t'(CAPACITY)))
      |=> (count_q == count_t'($past(count_q) + count_t'(1))))
    else $error("insert did not grow the store");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |-> (&order_ok))
    else $error("stored values out of order");

endmodule
